[hdl/eds_pkg.sv]
// shared types, widths and register codes for the diffusion stencil
package eds_pkg;

   localparam int MAX_COLS         = 1024;
   localparam int SAMPLE_BITS      = 16;
   localparam int WEIGHT_FRAC_BITS = 18;

   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int XW_BITS    = 18;
   localparam int CW_BITS    = 20;
   localparam int PCOLS_BITS = 11;
   localparam int PROWS_BITS = 16;
   localparam int ROW_BITS   = PROWS_BITS;

   localparam int SUM_BITS = SAMPLE_BITS + 1;
   localparam int PC_BITS  = CW_BITS + SUM_BITS;
   localparam int PX_BITS  = XW_BITS + SUM_BITS;
   localparam int ACC_BITS = PC_BITS + 2;
   localparam int Q_BITS   = ACC_BITS - WEIGHT_FRAC_BITS;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CW_BITS-1:0]    CENTER_RESET = CW_BITS'(1 << WEIGHT_FRAC_BITS);
   localparam logic [PCOLS_BITS-1:0] COLS_RESET   = PCOLS_BITS'(1024);
   localparam logic [PROWS_BITS-1:0] ROWS_RESET   = PROWS_BITS'(1024);

   typedef enum logic [2:0] {
      REG_X_WEIGHT      = 3'd0,
      REG_Y_WEIGHT      = 3'd1,
      REG_CENTER_WEIGHT = 3'd2,
      REG_PADDED_COLS   = 3'd3,
      REG_PADDED_ROWS   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [XW_BITS-1:0]    x_weight;
      logic [XW_BITS-1:0]    y_weight;
      logic [CW_BITS-1:0]    center_weight;
      logic [PCOLS_BITS-1:0] padded_cols;
      logic [PROWS_BITS-1:0] padded_rows;
   } cfg_type;

endpackage

[hdl/eds_if.sv]
// stream channel interfaces for samples in and updated thickness out
interface eds_req_if;
   logic                            valid;
   logic                            ready;
   logic [eds_pkg::SAMPLE_BITS-1:0] water_sample;
   logic                            frame_start;

   modport source (output valid, output water_sample, output frame_start, input ready);
   modport sink   (input valid, input water_sample, input frame_start, output ready);
endinterface

interface eds_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [eds_pkg::SAMPLE_BITS-1:0] new_thickness;
   logic                            last_of_frame;
   logic                            unstable;

   modport source (output valid, output new_thickness, output last_of_frame,
                   output unstable, input ready);
   modport sink   (input valid, input new_thickness, input last_of_frame,
                   input unstable, output ready);
endinterface

[hdl/eds_ram.sv]
// generic single-write, single-read ram with registered read data
module eds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read before write on a shared address
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/eds_csr.sv]
// apb register file holding the stencil weights and frame size
module eds_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [eds_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [eds_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [eds_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output eds_pkg::cfg_type                  cfg
);

   eds_pkg::cfg_type       cfg_ff;
   eds_pkg::cfg_type       cfg_in;
   eds_pkg::csr_index_type index;
   logic                   wr_strobe;

   assign index      = eds_pkg::csr_index_type'(csr_paddr[4:2]);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (index)
            eds_pkg::REG_X_WEIGHT:
               cfg_in.x_weight = csr_pwdata[eds_pkg::XW_BITS-1:0];
            eds_pkg::REG_Y_WEIGHT:
               cfg_in.y_weight = csr_pwdata[eds_pkg::XW_BITS-1:0];
            eds_pkg::REG_CENTER_WEIGHT:
               cfg_in.center_weight = csr_pwdata[eds_pkg::CW_BITS-1:0];
            eds_pkg::REG_PADDED_COLS:
               cfg_in.padded_cols = csr_pwdata[eds_pkg::PCOLS_BITS-1:0];
            eds_pkg::REG_PADDED_ROWS:
               cfg_in.padded_rows = csr_pwdata[eds_pkg::PROWS_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_weight      <= '0;
         cfg_ff.y_weight      <= '0;
         cfg_ff.center_weight <= eds_pkg::CENTER_RESET;
         cfg_ff.padded_cols   <= eds_pkg::COLS_RESET;
         cfg_ff.padded_rows   <= eds_pkg::ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         eds_pkg::REG_X_WEIGHT:
            csr_prdata = eds_pkg::CSR_DATA_BITS'(cfg_ff.x_weight);
         eds_pkg::REG_Y_WEIGHT:
            csr_prdata = eds_pkg::CSR_DATA_BITS'(cfg_ff.y_weight);
         eds_pkg::REG_CENTER_WEIGHT:
            csr_prdata = eds_pkg::CSR_DATA_BITS'(cfg_ff.center_weight);
         eds_pkg::REG_PADDED_COLS:
            csr_prdata = eds_pkg::CSR_DATA_BITS'(cfg_ff.padded_cols);
         eds_pkg::REG_PADDED_ROWS:
            csr_prdata = eds_pkg::CSR_DATA_BITS'(cfg_ff.padded_rows);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hdl/explicit_diffusion_stencil_top.sv]
// five-point explicit diffusion stencil over a streamed padded grid
// Takes one padded-grid sample per clock in raster order and, for every interior cell, returns
// one updated thickness when that cell's southern neighbour arrives, so a frame of R x C
// samples yields (R-2) x (C-2) beats. Sustained rate is one sample per cycle while the output
// does not stall; a result reaches the output register by way of the line-buffer read, launched
// at the accepting edge, then the neighbour sums, the three weight multipliers, the rounding
// adder and the saturating output register, each a register stage in that order. The two
// previous rows sit in block rams of MAX_COLS x 16 bits (the centre row is held twice to give a
// second read port for the east neighbour); they need no clearing pass, the block is ready
// straight after reset. A stall on the output freezes the whole pipeline and backpressures the
// input. Weights and sizes may only be written while no sample is in flight.
module explicit_diffusion_stencil_top (
   input  logic                              clock,
   input  logic                              reset,
   eds_req_if.sink                           req_if,
   eds_rsp_if.source                         rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [eds_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [eds_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [eds_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int CB = eds_pkg::COL_BITS;
   localparam int PC = eds_pkg::PCOLS_BITS;
   localparam int RB = eds_pkg::ROW_BITS;
   localparam int SB = eds_pkg::SAMPLE_BITS;
   localparam logic signed [eds_pkg::ACC_BITS-1:0] ROUND_HALF =
      eds_pkg::ACC_BITS'(1 << (eds_pkg::WEIGHT_FRAC_BITS - 1));

   eds_pkg::cfg_type cfg;

   eds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // pipeline moves as one while the output register can take a beat
   logic adv;
   logic accept;
   logic rsp_valid_ff;

   assign adv          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;
   assign accept       = req_if.valid && adv;

   // effective frame size
   logic [PC-1:0] cols_eff;
   logic [RB-1:0] rows_eff;

   always_comb begin
      cols_eff = cfg.padded_cols;
      if (cfg.padded_cols < PC'(3)) begin
         cols_eff = PC'(3);
      end else if (cfg.padded_cols > PC'(eds_pkg::MAX_COLS)) begin
         cols_eff = PC'(eds_pkg::MAX_COLS);
      end
      rows_eff = (cfg.padded_rows < RB'(3)) ? RB'(3) : cfg.padded_rows;
   end

   // raster position of the incoming sample
   logic [CB-1:0] col_pos_ff, col_pos_in;
   logic [RB-1:0] row_pos_ff, row_pos_in;
   logic [CB-1:0] col_base, col_a;
   logic [RB:0]   row_base, row_t, row_n;
   logic [RB-1:0] row_a;
   logic [PC-1:0] col_next;
   logic          col_wrap;
   logic          emit_a;
   logic          last_a;

   always_comb begin
      col_base = req_if.frame_start ? '0 : col_pos_ff;
      row_base = req_if.frame_start ? '0 : {1'b0, row_pos_ff};
      col_wrap = PC'(col_base) >= cols_eff;
      col_a    = col_wrap ? '0 : col_base;
      row_t    = col_wrap ? row_base + (RB+1)'(1) : row_base;
      row_a    = (row_t >= {1'b0, rows_eff}) ? '0 : row_t[RB-1:0];
      col_next = PC'(col_a) + PC'(1);

      emit_a = (row_a >= RB'(2)) && (col_a != '0) && (col_next < cols_eff);
      last_a = (({1'b0, row_a} + (RB+1)'(1)) == {1'b0, rows_eff})
               && ((PC'(col_a) + PC'(2)) == cols_eff);

      // step on, wrapping row and frame
      if (col_next >= cols_eff) begin
         col_pos_in = '0;
         row_n      = {1'b0, row_a} + (RB+1)'(1);
         row_pos_in = (row_n >= {1'b0, rows_eff}) ? '0 : row_n[RB-1:0];
      end else begin
         col_pos_in = col_next[CB-1:0];
         row_n      = {1'b0, row_a};
         row_pos_in = row_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (accept) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // line buffers: newer holds the previous row, older the one before
   logic [SB-1:0] center_rd, east_rd, north_rd;
   logic [CB-1:0] east_addr;
   logic          rd_valid_ff;
   logic          rd_emit_ff;
   logic          rd_last_ff;
   logic [CB-1:0] rd_col_ff;
   logic [SB-1:0] rd_sample_ff;
   logic          older_wr;

   assign east_addr = col_a + CB'(1);
   assign older_wr  = rd_valid_ff && adv;

   eds_ram #(.WIDTH(SB), .DEPTH(eds_pkg::MAX_COLS)) u_newer_center (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_a),
      .wr_data (req_if.water_sample),
      .rd_en   (accept),
      .rd_addr (col_a),
      .rd_data (center_rd)
   );

   eds_ram #(.WIDTH(SB), .DEPTH(eds_pkg::MAX_COLS)) u_newer_east (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_a),
      .wr_data (req_if.water_sample),
      .rd_en   (accept),
      .rd_addr (east_addr),
      .rd_data (east_rd)
   );

   eds_ram #(.WIDTH(SB), .DEPTH(eds_pkg::MAX_COLS)) u_older (
      .clock   (clock),
      .wr_en   (older_wr),
      .wr_addr (rd_col_ff),
      .wr_data (center_rd),
      .rd_en   (accept),
      .rd_addr (col_a),
      .rd_data (north_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (adv) begin
         rd_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_emit_ff   <= emit_a;
         rd_last_ff   <= last_a;
         rd_col_ff    <= col_a;
         rd_sample_ff <= req_if.water_sample;
      end
   end

   // west neighbour is the centre read by the beat before
   logic [SB-1:0] west_ff;

   always_ff @(posedge clock) begin
      if (older_wr) begin
         west_ff <= center_rd;
      end
   end

   // neighbour sums
   logic                         sum_valid_ff;
   logic                         sum_last_ff;
   logic [eds_pkg::SUM_BITS-1:0] sum_ns_ff, sum_ns_in;
   logic [eds_pkg::SUM_BITS-1:0] sum_ew_ff, sum_ew_in;
   logic [SB-1:0]                sum_center_ff;

   assign sum_ns_in = eds_pkg::SUM_BITS'(north_rd) + eds_pkg::SUM_BITS'(rd_sample_ff);
   assign sum_ew_in = eds_pkg::SUM_BITS'(east_rd) + eds_pkg::SUM_BITS'(west_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         sum_valid_ff <= rd_valid_ff && rd_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_last_ff   <= rd_last_ff;
         sum_ns_ff     <= sum_ns_in;
         sum_ew_ff     <= sum_ew_in;
         sum_center_ff <= center_rd;
      end
   end

   // weight products
   logic                                prod_valid_ff;
   logic                                prod_last_ff;
   logic signed [eds_pkg::PC_BITS-1:0]  prod_c_ff, prod_c_in;
   logic        [eds_pkg::PX_BITS-1:0]  prod_x_ff, prod_x_in;
   logic        [eds_pkg::PX_BITS-1:0]  prod_y_ff, prod_y_in;

   assign prod_c_in = $signed(cfg.center_weight) * $signed({1'b0, sum_center_ff});
   assign prod_x_in = eds_pkg::PX_BITS'(cfg.x_weight) * eds_pkg::PX_BITS'(sum_ns_ff);
   assign prod_y_in = eds_pkg::PX_BITS'(cfg.y_weight) * eds_pkg::PX_BITS'(sum_ew_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (adv) begin
         prod_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_last_ff <= sum_last_ff;
         prod_c_ff    <= prod_c_in;
         prod_x_ff    <= prod_x_in;
         prod_y_ff    <= prod_y_in;
      end
   end

   // accumulate with round-half-up
   logic                                acc_valid_ff;
   logic                                acc_last_ff;
   logic signed [eds_pkg::ACC_BITS-1:0] acc_ff, acc_in;

   assign acc_in = eds_pkg::ACC_BITS'(prod_c_ff)
                 + $signed(eds_pkg::ACC_BITS'(prod_x_ff))
                 + $signed(eds_pkg::ACC_BITS'(prod_y_ff))
                 + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else if (adv) begin
         acc_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_last_ff <= prod_last_ff;
         acc_ff      <= acc_in;
      end
   end

   // saturate into the output register
   logic [eds_pkg::Q_BITS-1:0] quot;
   logic [SB-1:0]              thick_in;
   logic [SB-1:0]              rsp_thick_ff;
   logic                       rsp_last_ff;
   logic                       rsp_unstable_ff;
   logic                       unstable_in;

   assign quot = acc_ff[eds_pkg::ACC_BITS-1:eds_pkg::WEIGHT_FRAC_BITS];

   always_comb begin
      if (acc_ff[eds_pkg::ACC_BITS-1]) begin
         thick_in = '0;
      end else if (quot[eds_pkg::Q_BITS-1:SB] != '0) begin
         thick_in = '1;
      end else begin
         thick_in = quot[SB-1:0];
      end
   end

   assign unstable_in = cfg.center_weight[eds_pkg::CW_BITS-1] || (cfg.center_weight == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= acc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_thick_ff    <= thick_in;
         rsp_last_ff     <= acc_last_ff;
         rsp_unstable_ff <= unstable_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.new_thickness = rsp_thick_ff;
   assign rsp_if.last_of_frame = rsp_last_ff;
   assign rsp_if.unstable      = rsp_unstable_ff;

   // a frame start always lands on column zero, so the next beat is column one
   a_frame_start_col : assert property (@(posedge clock) disable iff (reset)
      accept && req_if.frame_start |=> col_pos_ff == CB'(1))
      else $error("column counter not restarted by frame start");

   // the west register follows the centre read of the beat leaving the read stage
   // (row zero reads unwritten entries, so the comparison is case equality)
   a_west_tracks_center : assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && adv |=> west_ff === $past(center_rd))
      else $error("west neighbour register out of step");

   // a negative accumulator clamps to zero on the output
   a_negative_clamps : assert property (@(posedge clock) disable iff (reset)
      adv && acc_valid_ff && acc_ff[eds_pkg::ACC_BITS-1] |=> rsp_thick_ff == '0)
      else $error("negative sum not clamped");

   // a result beat moves from the multiplier stage to the adder stage when the pipe advances
   a_prod_to_acc : assert property (@(posedge clock) disable iff (reset)
      adv && prod_valid_ff |=> acc_valid_ff)
      else $error("beat lost between product and accumulate stages");

endmodule

[tb/tb.sv]
// self-checking testbench for the five-point diffusion stencil top level
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [eds_pkg::SAMPLE_BITS-1:0] water_sample;
      logic                            frame_start;
   } sample_beat_type;

   typedef struct packed {
      logic [eds_pkg::SAMPLE_BITS-1:0] new_thickness;
      logic                            last_of_frame;
      logic                            unstable;
   } thickness_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [eds_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [eds_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [eds_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   eds_req_if req_if ();
   eds_rsp_if rsp_if ();

   explicit_diffusion_stencil_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // predictor state: registers, line buffers and raster position
   logic [eds_pkg::XW_BITS-1:0]        x_w      = '0;
   logic [eds_pkg::XW_BITS-1:0]        y_w      = '0;
   logic signed [eds_pkg::CW_BITS-1:0] center_w = eds_pkg::CENTER_RESET;
   logic [eds_pkg::PCOLS_BITS-1:0]     pad_cols = eds_pkg::COLS_RESET;
   logic [eds_pkg::PROWS_BITS-1:0]     pad_rows = eds_pkg::ROWS_RESET;
   logic [eds_pkg::SAMPLE_BITS-1:0]    older_line [eds_pkg::MAX_COLS];
   logic [eds_pkg::SAMPLE_BITS-1:0]    newer_line [eds_pkg::MAX_COLS];
   int unsigned                        col_at = 0;
   int unsigned                        row_at = 0;

   sample_beat_type    sample_queue [$];
   thickness_beat_type thickness_expect [$];
   int unsigned        queued_beats   = 0;
   int unsigned        accepted_beats = 0;
   int unsigned        mismatch_count = 0;

   function automatic int unsigned active_cols();
      if (pad_cols < 3) return 3;
      if (pad_cols > eds_pkg::MAX_COLS) return eds_pkg::MAX_COLS;
      return pad_cols;
   endfunction

   function automatic int unsigned active_rows();
      if (pad_rows < 3) return 3;
      return pad_rows;
   endfunction

   // advance the raster by one sample and record the updated cell, if any
   function automatic void advance_stencil(logic [eds_pkg::SAMPLE_BITS-1:0] sample,
                                           logic fstart);
      int unsigned        cols;
      int unsigned        rows;
      int unsigned        col;
      int unsigned        row;
      longint             acc;
      longint             cw;
      thickness_beat_type res;
      cols = active_cols();
      rows = active_rows();
      if (fstart) begin
         col_at = 0;
         row_at = 0;
      end
      if (col_at >= cols) begin
         col_at = 0;
         row_at++;
      end
      if (row_at >= rows) row_at = 0;
      col = col_at;
      row = row_at;
      if (row >= 2 && col >= 1 && col + 1 < cols) begin
         cw  = center_w;
         acc = cw * longint'(newer_line[col])
             + longint'(x_w) * (longint'(older_line[col]) + longint'(sample))
             + longint'(y_w) * (longint'(newer_line[col + 1]) + longint'(older_line[col - 1]))
             + (longint'(1) << (eds_pkg::WEIGHT_FRAC_BITS - 1));
         if (acc < 0) acc = 0;
         else begin
            acc = acc >>> eds_pkg::WEIGHT_FRAC_BITS;
            if (acc > (longint'(1) << eds_pkg::SAMPLE_BITS) - 1)
               acc = (longint'(1) << eds_pkg::SAMPLE_BITS) - 1;
         end
         res.new_thickness = acc[eds_pkg::SAMPLE_BITS-1:0];
         res.last_of_frame = (row + 1 == rows) && (col + 2 == cols);
         res.unstable      = (center_w <= 0);
         thickness_expect.push_back(res);
      end
      older_line[col] = newer_line[col];
      newer_line[col] = sample;
      col++;
      if (col >= cols) begin
         col = 0;
         row++;
         if (row >= rows) row = 0;
      end
      col_at = col;
      row_at = row & 32'hFFFF;
   endfunction

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      mismatch_count++;
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
   endtask

   // input side: one beat per item, random gap after each
   int unsigned req_gap    = 0;
   bit          req_steady = 1'b0;

   initial begin
      req_if.valid        = 1'b0;
      req_if.water_sample = '0;
      req_if.frame_start  = 1'b0;
      rsp_if.ready        = 1'b0;
   end

   always @(posedge clock) begin
      sample_beat_type beat;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            advance_stencil(req_if.water_sample, req_if.frame_start);
            accepted_beats++;
         end
         if (req_if.valid && !req_if.ready) begin
            // beat held until taken
         end else if (req_gap != 0) begin
            req_if.valid <= 1'b0;
            req_gap      <= req_gap - 1;
         end else if (sample_queue.size() != 0) begin
            beat = sample_queue.pop_front();
            req_if.valid        <= 1'b1;
            req_if.water_sample <= beat.water_sample;
            req_if.frame_start  <= beat.frame_start;
            if ($urandom_range(0, 63) == 0) req_steady <= !req_steady;
            req_gap <= req_steady ? 0 : $urandom_range(0, 3);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result side: check each beat, then stall for a random while
   int unsigned rsp_stall  = 0;
   bit          rsp_steady = 1'b0;

   always @(posedge clock) begin
      thickness_beat_type want;
      int unsigned        draw;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (thickness_expect.size() == 0) begin
               report_mismatch("unexpected beat", rsp_if.new_thickness, 0);
            end else begin
               want = thickness_expect.pop_front();
               if (rsp_if.new_thickness !== want.new_thickness)
                  report_mismatch("new_thickness", rsp_if.new_thickness, want.new_thickness);
               if (rsp_if.last_of_frame !== want.last_of_frame)
                  report_mismatch("last_of_frame", rsp_if.last_of_frame, want.last_of_frame);
               if (rsp_if.unstable !== want.unstable)
                  report_mismatch("unstable", rsp_if.unstable, want.unstable);
            end
            if ($urandom_range(0, 47) == 0) rsp_steady <= !rsp_steady;
            draw = rsp_steady ? 0 : $urandom_range(0, 3);
            rsp_stall    <= draw;
            rsp_if.ready <= (draw == 0);
         end else if (rsp_stall != 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_if.ready <= (rsp_stall == 1);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(eds_pkg::csr_index_type idx,
                            logic [eds_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         eds_pkg::REG_X_WEIGHT:      x_w      = value[eds_pkg::XW_BITS-1:0];
         eds_pkg::REG_Y_WEIGHT:      y_w      = value[eds_pkg::XW_BITS-1:0];
         eds_pkg::REG_CENTER_WEIGHT: center_w = value[eds_pkg::CW_BITS-1:0];
         eds_pkg::REG_PADDED_COLS:   pad_cols = value[eds_pkg::PCOLS_BITS-1:0];
         eds_pkg::REG_PADDED_ROWS:   pad_rows = value[eds_pkg::PROWS_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_grid(int unsigned xw, int unsigned yw, int cw,
                               int unsigned pc, int unsigned pr);
      csr_write(eds_pkg::REG_X_WEIGHT, xw);
      csr_write(eds_pkg::REG_Y_WEIGHT, yw);
      csr_write(eds_pkg::REG_CENTER_WEIGHT, 32'(cw));
      csr_write(eds_pkg::REG_PADDED_COLS, pc);
      csr_write(eds_pkg::REG_PADDED_ROWS, pr);
   endtask

   // wait until every beat is taken and answered, then let the pipe empty
   task automatic drain();
      while (accepted_beats != queued_beats || thickness_expect.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void queue_sample(logic [eds_pkg::SAMPLE_BITS-1:0] s, logic f);
      sample_queue.push_back('{water_sample: s, frame_start: f});
      queued_beats++;
   endfunction

   function automatic logic [eds_pkg::SAMPLE_BITS-1:0] draw_sample();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return eds_pkg::SAMPLE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic draw_weights(output int unsigned xw, output int unsigned yw, output int cw);
      if ($urandom_range(0, 3) == 0) begin
         xw = $urandom_range(0, 131072);
         yw = $urandom_range(0, 131072);
         cw = int'($urandom_range(0, 524288)) - 262144;
      end else begin
         // physically sensible weights: centre is one minus the neighbour weights
         xw = $urandom_range(0, 65536);
         yw = $urandom_range(0, 65536);
         cw = 262144 - 2 * int'(xw) - 2 * int'(yw);
      end
   endtask

   initial begin
      int unsigned random_beats;
      int unsigned cells;
      int unsigned n;
      int unsigned kind;
      int unsigned xw;
      int unsigned yw;
      int          cw;
      int unsigned pc;
      int unsigned pr;
      bit          stores_full;
      random_beats = 0;
      stores_full  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest grid, full weights, all samples at the top: saturates high
      program_grid(131072, 131072, 262144, 3, 3);
      for (int i = 0; i < 9; i++) queue_sample('1, i == 0);
      drain();
      // negative centre, no frame start: wraps into a new frame, clamps to zero
      program_grid(0, 0, -262144, 3, 3);
      for (int i = 0; i < 9; i++) queue_sample('1, 1'b0);
      drain();
      // zero centre with a half-way sum: rounds up
      program_grid(131072, 0, 0, 3, 3);
      for (int i = 0; i < 9; i++) queue_sample(i == 1, i == 0);
      drain();

      while (random_beats < 1600) begin
         kind = $urandom_range(0, 9);
         draw_weights(xw, yw, cw);
         if (kind >= 6 && kind <= 7 && stores_full) begin
            // shrink mid-frame, position may now lie beyond the new edges
            pc = $urandom_range(3, active_cols());
            pr = $urandom_range(3, active_rows());
            program_grid(xw, yw, cw, pc, pr);
            cells = active_cols() * active_rows();
            n = $urandom_range(1, 2) * cells;
            for (int i = 0; i < n; i++) queue_sample(draw_sample(), 1'b0);
         end else begin
            case ($urandom_range(0, 9))
               0:       pc = $urandom_range(0, 2);
               1:       pc = $urandom_range(13, 40);
               default: pc = $urandom_range(3, 12);
            endcase
            pr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            program_grid(xw, yw, cw, pc, pr);
            cells = active_cols() * active_rows();
            if (kind >= 8) begin
               // short broken bursts with stray frame starts
               n = $urandom_range(1, 40);
               for (int i = 0; i < n; i++)
                  queue_sample(draw_sample(), i == 0 || $urandom_range(0, 7) == 0);
               stores_full = 1'b0;
            end else begin
               n = $urandom_range(1, 2) * cells + $urandom_range(0, cells - 1);
               for (int i = 0; i < n; i++)
                  queue_sample(draw_sample(),
                               i == 0 || (i % cells == 0 && $urandom_range(0, 1) == 0));
               stores_full = 1'b1;
            end
         end
         random_beats += n;
         drain();
      end

      if (mismatch_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
